FILE: rtl/core/pgs_pkg.sv
// ============================================================================
// pgs_pkg: shared types and constants for the propensity group sampler
// Holds the beat structs, the sizes and the helper that bins a rate into a group.
// ============================================================================
package pgs_pkg;

   localparam int NumReactions = 1024;
   localparam int NumGroups    = 32;
   localparam int IdxW         = 10;
   localparam int GrpW         = 5;
   localparam int CntW         = 11;
   localparam int RateW        = 47;
   localparam int SumW         = 57;
   localparam int SlotW        = GrpW + IdxW;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic             cmd;
      logic [IdxW-1:0]  reaction_index;
      logic [RateW-1:0] propensity;
      logic [31:0]      rand_group;
      logic [31:0]      rand_member;
      logic [15:0]      rand_accept;
   } req_type;

   typedef struct packed {
      logic [IdxW-1:0] chosen_reaction;
      logic            accepted;
      logic [SumW-1:0] total_propensity;
      logic            error;
   } rsp_type;

   // Group of a rate: 0 for zero, at least 1, else bit length of the integer
   // part; that length is at most 31, the top group.
   function automatic logic [GrpW-1:0] group_of(input logic [RateW-1:0] rate);
      logic [GrpW-1:0] bl;
      bl = '0;
      for (int i = 0; i < RateW - 16; i++) begin
         if (rate[16+i]) bl = GrpW'(i + 1);
      end
      if (rate == '0) return '0;
      if (bl == '0) bl = GrpW'(1);
      return bl;
   endfunction

endpackage

FILE: rtl/core/pgs_mul.sv
// ============================================================================
// pgs_mul: shared 32 by 32 multiplier
// Registered product used for the draw scaling and the member pick.
// ============================================================================
module pgs_mul
   import pgs_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] p_ff
);
   logic [63:0] p_in;
   assign p_in = 64'(a) * 64'(b);
   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end
endmodule

FILE: rtl/core/propensity_group_sampler_unit.sv
// ============================================================================
// propensity_group_sampler_unit: composition-rejection sampler
// Keeps rates, group member lists and group sums; updates or samples.
// ============================================================================
// After reset the block sweeps the group 0 member list and the position, rate
// and group memories before req_ready rises. An update beat with an unchanged
// rate ends after ST_URD and ST_URD2; one that stays in its group adds ST_UREM
// and the rebuild of the total from the group sums in ST_UTOT, and one that
// changes group also adds ST_UREM2, ST_UREM3 and ST_UAPP. A sample beat forms
// the scaled draw in ST_M0 to ST_M3, the walk over the 31 group sums reads one
// sum per cycle, and the member pick, member read and rejection compare take
// ST_MB0, ST_MB1, ST_MRD, ST_MRD2 and ST_ACC. The shared 32x32 multiplier is
// used three times. One beat is worked on at a time; the result waits in an
// output register, and the next beat is taken while it waits. A beat only
// stalls at its end if the previous result has still not been taken.
module propensity_group_sampler_unit
   import pgs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [19:0] {
      ST_INIT  = 20'h00001, ST_IDLE  = 20'h00002, ST_URD   = 20'h00004,
      ST_URD2  = 20'h00008, ST_UREM  = 20'h00010, ST_UREM2 = 20'h00020,
      ST_UREM3 = 20'h00040, ST_UAPP  = 20'h00080, ST_UTOT  = 20'h00100,
      ST_M0    = 20'h00200, ST_M1    = 20'h00400, ST_M2    = 20'h00800,
      ST_M3    = 20'h01000, ST_WALK  = 20'h02000, ST_MB0   = 20'h04000,
      ST_MB1   = 20'h08000, ST_MRD   = 20'h10000, ST_MRD2  = 20'h20000,
      ST_ACC   = 20'h40000, ST_DONE  = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   // Memories: rates and group per reaction, position per reaction, member lists.
   logic [RateW-1:0] rate_mem [NumReactions];
   logic [GrpW-1:0]  grp_mem  [NumReactions];
   logic [IdxW-1:0]  pos_mem  [NumReactions];
   logic [IdxW-1:0]  lst_mem  [NumReactions*NumGroups];

   logic [CntW-1:0] cnt_ff [NumGroups];
   logic [SumW-1:0] gsum_ff [NumGroups];
   logic [SumW-1:0] total_ff;

   req_type req_ff;
   rsp_type rsp_ff;
   rsp_type wrk_ff;
   logic    rsp_valid_ff;
   logic    rsp_load;

   logic [IdxW:0]    init_ff;
   logic [GrpW-1:0]  g_ff;
   logic [GrpW-1:0]  gnew_ff;
   logic [RateW-1:0] pold_ff;
   logic [IdxW-1:0]  pos_ff;
   logic [SumW-1:0]  acc_ff;
   logic [63:0]      draw_ff;
   logic [IdxW-1:0]  r_ff;

   // Memory read ports, registered.
   logic [IdxW-1:0]  ra_idx;
   logic [SlotW-1:0] ra_slot;
   logic [RateW-1:0] rate_q;
   logic [GrpW-1:0]  grp_q;
   logic [IdxW-1:0]  lst_q;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   pgs_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p_ff(mul_p));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The finished result moves to the output register once it is free.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   logic [CntW-1:0] last_cnt;
   assign last_cnt = cnt_ff[g_ff] - CntW'(1);

   always_comb begin
      mul_a = 32'(total_ff >> 32);
      mul_b = req_ff.rand_group;
      unique case (state_ff)
         ST_M0:   mul_a = 32'(total_ff >> 32);
         ST_M1:   mul_a = total_ff[31:0];
         ST_MB0:  begin
            mul_a = 32'(cnt_ff[g_ff]);
            mul_b = req_ff.rand_member;
         end
         default: mul_a = 32'(total_ff >> 32);
      endcase
   end

   always_comb begin
      ra_idx  = req_ff.reaction_index;
      ra_slot = {g_ff, last_cnt[IdxW-1:0]};
      if (state_ff == ST_MRD || state_ff == ST_MRD2 || state_ff == ST_ACC) begin
         ra_idx = r_ff;
      end
      if (state_ff == ST_MB1 || state_ff == ST_MRD) begin
         ra_slot = {g_ff, (mul_p[63:32] >= 32'(NumReactions))
                    ? IdxW'(NumReactions - 1) : mul_p[32+IdxW-1:32]};
      end
   end

   always_ff @(posedge clock) begin
      rate_q <= rate_mem[ra_idx];
      grp_q  <= grp_mem[ra_idx];
      lst_q  <= lst_mem[ra_slot];
      pos_ff <= (state_ff == ST_URD) ? pos_mem[ra_idx] : pos_ff;
   end

   logic [SumW-1:0] cum_next;
   assign cum_next = acc_ff + gsum_ff[g_ff];

   always_comb begin
      state_in = state_ff;
      priority case (state_ff)
         ST_INIT:  if (init_ff == (IdxW+1)'(NumReactions - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid && req_ready) begin
            state_in = (req_data.cmd == CMD_SAMPLE) ? ST_M0 : ST_URD;
         end
         ST_URD:   state_in = ST_URD2;
         ST_URD2:  state_in = (rate_q == req_ff.propensity) ? ST_DONE : ST_UREM;
         ST_UREM:  state_in = (gnew_ff == g_ff) ? ST_UTOT : ST_UREM2;
         ST_UREM2: state_in = ST_UREM3;
         ST_UREM3: state_in = ST_UAPP;
         ST_UAPP:  state_in = ST_UTOT;
         ST_UTOT:  state_in = (g_ff == GrpW'(NumGroups - 1)) ? ST_DONE : ST_UTOT;
         ST_M0:    state_in = ST_M1;
         ST_M1:    state_in = ST_M2;
         ST_M2:    state_in = ST_M3;
         ST_M3:    state_in = ST_WALK;
         ST_WALK:  begin
            if (gsum_ff[g_ff] != '0 && draw_ff <= 64'(cum_next)) begin
               state_in = (cnt_ff[g_ff] == '0) ? ST_DONE : ST_MB0;
            end else if (g_ff == GrpW'(NumGroups - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_MB0:   state_in = ST_MB1;
         ST_MB1:   state_in = ST_MRD;
         ST_MRD:   state_in = ST_MRD2;
         ST_MRD2:  state_in = ST_ACC;
         ST_ACC:   state_in = ST_DONE;
         ST_DONE:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         for (int g = 0; g < NumGroups; g++) begin
            cnt_ff[g]  <= (g == 0) ? CntW'(NumReactions) : '0;
            gsum_ff[g] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_ff       <= wrk_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               init_ff <= init_ff + (IdxW+1)'(1);
               lst_mem[{GrpW'(0), init_ff[IdxW-1:0]}] <= init_ff[IdxW-1:0];
               pos_mem[init_ff[IdxW-1:0]]  <= init_ff[IdxW-1:0];
               rate_mem[init_ff[IdxW-1:0]] <= '0;
               grp_mem[init_ff[IdxW-1:0]]  <= '0;
            end
            ST_IDLE: if (req_valid && req_ready) begin
               req_ff <= req_data;
               wrk_ff <= '{chosen_reaction: '0, accepted: 1'b0,
                           total_propensity: total_ff, error: 1'b0};
               gnew_ff <= group_of(req_data.propensity);
               g_ff   <= GrpW'(1);
               acc_ff <= '0;
            end
            ST_URD2: begin
               g_ff    <= grp_q;
               pold_ff <= rate_q;
            end
            ST_UREM: begin
               gsum_ff[g_ff]   <= gsum_ff[g_ff] - SumW'(pold_ff) +
                                  ((gnew_ff == g_ff) ? SumW'(req_ff.propensity) : '0);
               if (gnew_ff != g_ff)
                  gsum_ff[gnew_ff] <= gsum_ff[gnew_ff] + SumW'(req_ff.propensity);
               rate_mem[req_ff.reaction_index] <= req_ff.propensity;
               if (gnew_ff == g_ff) begin
                  g_ff <= GrpW'(1);
               end
            end
            ST_UREM2: ;  // last member of the old group is being read
            ST_UREM3: begin
               lst_mem[{g_ff, pos_ff}] <= lst_q;
               pos_mem[lst_q] <= pos_ff;
               cnt_ff[g_ff] <= last_cnt;
            end
            ST_UAPP: begin
               lst_mem[{gnew_ff, cnt_ff[gnew_ff][IdxW-1:0]}] <= req_ff.reaction_index;
               grp_mem[req_ff.reaction_index] <= gnew_ff;
               pos_mem[req_ff.reaction_index] <= cnt_ff[gnew_ff][IdxW-1:0];
               cnt_ff[gnew_ff] <= cnt_ff[gnew_ff] + CntW'(1);
               g_ff <= GrpW'(1);
            end
            ST_UTOT: begin
               acc_ff <= cum_next;
               g_ff   <= g_ff + GrpW'(1);
               if (g_ff == GrpW'(NumGroups - 1)) begin
                  total_ff <= cum_next;
                  wrk_ff.total_propensity <= cum_next;
               end
            end
            ST_M0: ;
            ST_M1: draw_ff <= mul_p;                  // high part times u
            ST_M2: draw_ff <= draw_ff + 64'(mul_p[63:32]);
            ST_M3: wrk_ff.total_propensity <= total_ff;
            ST_WALK: begin
               acc_ff <= cum_next;
               if (!(gsum_ff[g_ff] != '0 && draw_ff <= 64'(cum_next))) begin
                  g_ff <= g_ff + GrpW'(1);
                  if (g_ff == GrpW'(NumGroups - 1)) wrk_ff.error <= 1'b1;
               end else if (cnt_ff[g_ff] == '0) begin
                  wrk_ff.error <= 1'b1;
               end
            end
            ST_MB0: ;
            ST_MB1: ;
            ST_MRD: r_ff <= lst_q;
            ST_MRD2: ;
            ST_ACC: if (!wrk_ff.error) begin
               wrk_ff.chosen_reaction <= r_ff;
               wrk_ff.accepted <= ((64'(req_ff.rand_accept) << g_ff) <= 64'(rate_q));
            end
            ST_DONE: ;
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("held result changed");
   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> rsp_data.chosen_reaction == '0 && !rsp_data.accepted)
      else $error("error result carries a pick");
endmodule
